/* hw/rtl/hpq_pkg.sv */
// shared codes for the binary heap priority queue
package hpq_pkg;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic ORDER_MAX = 1'b0;
	localparam logic ORDER_MIN = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

endpackage

/* hw/rtl/hpq_mem.sv */
// heap entry store: one write port, two registered read ports
module hpq_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= mem_q[raddr_a];
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* hw/rtl/hpq_cmp.sv */
// shared key compare: true when key a ranks strictly above key b
module hpq_cmp #(
	parameter int KEY_WIDTH = 16
) (
	input  logic [KEY_WIDTH-1:0] a_key,
	input  logic [KEY_WIDTH-1:0] b_key,
	input  logic                 order_mode,
	output logic                 outranks
);
	import hpq_pkg::*;

	always_comb begin
		if (order_mode == ORDER_MIN) begin
			outranks = a_key < b_key;
		end else begin
			outranks = a_key > b_key;
		end
	end

endmodule

/* hw/rtl/binary_heap_priority_queue_unit.sv */
// binary heap priority queue: sequencer around one store and one compare unit
//
//  channel   signals                               beat taken when
//  -------   -----------------------------------   -------------------------
//  command   start busy kind key tag               start high, busy low
//  result    done top_key top_tag top_valid        done high (one cycle)
//            count error
//  config    cfg_we cfg_wdata                      cfg_we high
//
// a push reads the parent and compares against it for each level climbed, then
// writes at the root or where it stops; a pop reads and loads the last entry,
// then compares both children and writes for each level descended.
// each level is one store read and one or two turns of the single key compare.
// refused beats (push when full, pop when empty) finish without busy going high.
// done rises in the same cycle that busy falls; no result can stall.
// reset empties the queue and clears the order bit; the store is not cleared.
module binary_heap_priority_queue_unit #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 16,
	parameter int TAG_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [KEY_WIDTH-1:0]              key,
	input  logic [TAG_WIDTH-1:0]              tag,
	output logic                              done,
	output logic [KEY_WIDTH-1:0]              top_key,
	output logic [TAG_WIDTH-1:0]              top_tag,
	output logic                              top_valid,
	output logic [$clog2(CAPACITY+1)-1:0]     count,
	output hpq_pkg::err_t                     error,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata
);
	import hpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;
	localparam int EW = KEY_WIDTH + TAG_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_POP_RD,
		S_POP_LD,
		S_DN_CL,
		S_DN_CR
	} state_t;

	state_t        state_q;
	logic          done_q;
	err_t          err_q;
	logic [CW-1:0] count_q;
	logic          order_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] lidx_q;
	logic [AW-1:0] ridx_q;
	logic          l_ok_q;
	logic          r_ok_q;
	logic          best_l_q;
	logic [EW-1:0] e_q;
	logic [EW-1:0] top_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr_a;
	logic [AW-1:0] mem_raddr_b;
	logic [EW-1:0] rd_a;
	logic [EW-1:0] rd_b;

	logic [KEY_WIDTH-1:0] cmp_a;
	logic [KEY_WIDTH-1:0] cmp_b;
	logic                 cmp_out;

	logic [AW-1:0] parent;
	logic [AW-1:0] base_pos;
	logic [XW-1:0] lc;
	logic [XW-1:0] rc;
	logic [XW-1:0] cnt_x;
	logic          l_ok_n;
	logic          r_ok_n;
	logic          r_win;
	logic          dn_move;
	logic          accept;

	hpq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	hpq_cmp #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_cmp (
		.a_key      (cmp_a),
		.b_key      (cmp_b),
		.order_mode (order_q),
		.outranks   (cmp_out)
	);

	assign accept = start && !busy;

	// compare operand selection
	always_comb begin
		cmp_a = e_q[EW-1:TAG_WIDTH];
		cmp_b = e_q[EW-1:TAG_WIDTH];
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = e_q[EW-1:TAG_WIDTH];
				cmp_b = rd_a[EW-1:TAG_WIDTH];
			end
			S_DN_CL: begin
				cmp_a = rd_a[EW-1:TAG_WIDTH];
				cmp_b = e_q[EW-1:TAG_WIDTH];
			end
			S_DN_CR: begin
				cmp_a = rd_b[EW-1:TAG_WIDTH];
				cmp_b = best_l_q ? rd_a[EW-1:TAG_WIDTH] : e_q[EW-1:TAG_WIDTH];
			end
			default: begin
			end
		endcase
	end

	// child and parent addressing
	always_comb begin
		parent   = AW'((pos_q - 1'b1) >> 1);
		r_win    = (state_q == S_DN_CR) && r_ok_q && cmp_out;
		dn_move  = (state_q == S_DN_CR) && (r_win || best_l_q);
		base_pos = '0;
		if (state_q == S_DN_CR) begin
			base_pos = r_win ? ridx_q : lidx_q;
		end
		lc     = {1'b0, base_pos, 1'b1};
		rc     = {1'b0, base_pos, 1'b0} + XW'(2);
		cnt_x  = XW'(count_q);
		l_ok_n = lc < cnt_x;
		r_ok_n = rc < cnt_x;
	end

	// store port control
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = e_q;
		mem_re      = 1'b0;
		mem_raddr_a = l_ok_n ? lc[AW-1:0] : '0;
		mem_raddr_b = r_ok_n ? rc[AW-1:0] : '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_UP: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re      = 1'b1;
					mem_raddr_a = parent;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp_out) begin
					mem_wdata = rd_a;
				end
			end
			S_POP_RD: begin
				mem_re      = 1'b1;
				mem_raddr_a = count_q[AW-1:0];
			end
			S_POP_LD: begin
				mem_re = (count_q != '0);
			end
			S_DN_CL: begin
			end
			S_DN_CR: begin
				mem_we = 1'b1;
				if (r_win) begin
					mem_wdata = rd_b;
				end else if (best_l_q) begin
					mem_wdata = rd_a;
				end
				mem_re = dn_move;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			err_q    <= ERR_OK;
			count_q  <= '0;
			order_q  <= ORDER_MAX;
			pos_q    <= '0;
			lidx_q   <= '0;
			ridx_q   <= '0;
			l_ok_q   <= 1'b0;
			r_ok_q   <= 1'b0;
			best_l_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_PUSH) begin
							if (count_q == CW'(CAPACITY)) begin
								done_q <= 1'b1;
								err_q  <= ERR_FULL;
							end else begin
								pos_q   <= count_q[AW-1:0];
								count_q <= count_q + 1'b1;
								state_q <= S_UP;
							end
						end else begin
							if (count_q == '0) begin
								done_q <= 1'b1;
								err_q  <= ERR_EMPTY;
							end else begin
								count_q <= count_q - 1'b1;
								state_q <= S_POP_RD;
							end
						end
					end
				end
				S_UP: begin
					if (pos_q == '0) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						err_q   <= ERR_OK;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cmp_out) begin
						pos_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						err_q   <= ERR_OK;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_LD;
				end
				S_POP_LD: begin
					if (count_q == '0) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						err_q   <= ERR_OK;
					end else begin
						pos_q   <= '0;
						lidx_q  <= lc[AW-1:0];
						ridx_q  <= rc[AW-1:0];
						l_ok_q  <= l_ok_n;
						r_ok_q  <= r_ok_n;
						state_q <= S_DN_CL;
					end
				end
				S_DN_CL: begin
					best_l_q <= l_ok_q && cmp_out;
					state_q  <= S_DN_CR;
				end
				S_DN_CR: begin
					if (dn_move) begin
						pos_q   <= base_pos;
						lidx_q  <= lc[AW-1:0];
						ridx_q  <= rc[AW-1:0];
						l_ok_q  <= l_ok_n;
						r_ok_q  <= r_ok_n;
						state_q <= S_DN_CL;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						err_q   <= ERR_OK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// moving entry and root copy
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_PUSH)) begin
			e_q <= {key, tag};
		end else if (state_q == S_POP_LD) begin
			e_q <= rd_a;
		end
		if (mem_we && (mem_waddr == '0)) begin
			top_q <= mem_wdata;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign error     = err_q;
	assign count     = count_q;
	assign top_valid = (count_q != '0);
	assign top_key   = top_valid ? top_q[EW-1:TAG_WIDTH] : '0;
	assign top_tag   = top_valid ? top_q[TAG_WIDTH-1:0] : '0;

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sift ended without a result beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error == ERR_FULL)) |-> (count_q == CW'(CAPACITY)))
		else $error("push refused while not full");

	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error == ERR_EMPTY)) |-> (count_q == '0))
		else $error("pop refused while not empty");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("store written while idle");

endmodule
